// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// implication checked on every rising edge, off while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/ansp_pkg.sv -----
package ansp_pkg;

	// bytes held back in the window
	localparam int unsigned HOLD_DEPTH = 4;

	localparam logic [2:0] CODE_LEN_3 = 3'd3;
	localparam logic [2:0] CODE_LEN_4 = 3'd4;
	localparam logic [2:0] HOLD_FULL  = 3'd4;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE  = 8'h01;

	// group of 0..4 output words produced by one input word
	typedef struct packed {
		logic [HOLD_DEPTH-1:0][7:0] bytes;
		logic [2:0]                 cnt;
		logic                       first;
		logic                       last;
		logic [2:0]                 code_len;
	} bundle_t;

	// queue head as seen by the back end
	typedef struct packed {
		bundle_t head;
		logic    empty;
	} q_stat_t;

endpackage

// ----- rtl/core/ansp_if.sv -----
// input word channel
interface ansp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       stream_end;

	modport source (output valid, output in_byte, output stream_end, input ready);
	modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

// output word channel
interface ansp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       unit_first;
	logic       unit_last;
	logic [2:0] code_length;

	modport source (output valid, output out_byte, output unit_first, output unit_last,
		output code_length, input ready);
	modport sink (input valid, input out_byte, input unit_first, input unit_last,
		input code_length, output ready);
endinterface

// ----- rtl/core/ansp_front.sv -----
`include "assert_macros.svh"

module ansp_front (
	input  logic              clk,
	input  logic              arst_n,
	ansp_in_if.sink           up,
	input  logic              q_full,
	output logic              push,
	output ansp_pkg::bundle_t bundle
);

	logic [ansp_pkg::HOLD_DEPTH-1:0][7:0] win_q;
	logic [2:0] held_q;
	logic       inside_q;
	logic [2:0] len_q;
	logic       firstp_q;

	logic       accept;
	logic       ge2;
	logic       ge3;
	logic [7:0] p1;
	logic [7:0] p2;
	logic [7:0] p3;
	logic       is_one;
	logic       code3;
	logic       code4;

	assign up.ready = !q_full;
	assign accept   = up.valid && up.ready;
	assign push     = accept && (bundle.cnt != 3'd0);

	// bytes just before the new one
	always_comb begin
		ge2 = 1'b0;
		ge3 = 1'b0;
		p1  = ansp_pkg::BYTE_ONE;
		p2  = ansp_pkg::BYTE_ONE;
		p3  = ansp_pkg::BYTE_ONE;
		case (held_q)
			3'd2: begin
				ge2 = 1'b1;
				p1  = win_q[1];
				p2  = win_q[0];
			end
			3'd3: begin
				ge2 = 1'b1;
				ge3 = 1'b1;
				p1  = win_q[2];
				p2  = win_q[1];
				p3  = win_q[0];
			end
			3'd4: begin
				ge2 = 1'b1;
				ge3 = 1'b1;
				p1  = win_q[3];
				p2  = win_q[2];
				p3  = win_q[1];
			end
			default: begin
				ge2 = 1'b0;
			end
		endcase
	end

	assign is_one = (up.in_byte == ansp_pkg::BYTE_ONE);
	assign code4  = is_one && ge3 && (p1 == ansp_pkg::BYTE_ZERO)
		&& (p2 == ansp_pkg::BYTE_ZERO) && (p3 == ansp_pkg::BYTE_ZERO);
	assign code3  = is_one && ge2 && (p1 == ansp_pkg::BYTE_ZERO)
		&& (p2 == ansp_pkg::BYTE_ZERO) && !code4;

	// words released by this input, always the oldest held bytes
	always_comb begin
		bundle.bytes    = win_q;
		bundle.cnt      = 3'd0;
		bundle.first    = firstp_q;
		bundle.last     = 1'b1;
		bundle.code_len = len_q;
		if (up.stream_end) begin
			bundle.cnt = inside_q ? held_q : 3'd0;
		end else if (code4) begin
			bundle.cnt = inside_q ? (held_q - 3'd3) : 3'd0;
		end else if (code3) begin
			bundle.cnt = inside_q ? (held_q - 3'd2) : 3'd0;
		end else if (held_q == ansp_pkg::HOLD_FULL) begin
			bundle.cnt  = inside_q ? 3'd1 : 3'd0;
			bundle.last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			held_q   <= 3'd0;
			inside_q <= 1'b0;
			len_q    <= ansp_pkg::CODE_LEN_3;
			firstp_q <= 1'b0;
		end else if (accept) begin
			if (up.stream_end) begin
				win_q    <= '0;
				held_q   <= 3'd0;
				inside_q <= 1'b0;
				len_q    <= ansp_pkg::CODE_LEN_3;
				firstp_q <= 1'b0;
			end else if (code4 || code3) begin
				// window becomes just the start code
				if (code4) begin
					win_q  <= {ansp_pkg::BYTE_ONE, ansp_pkg::BYTE_ZERO,
						ansp_pkg::BYTE_ZERO, ansp_pkg::BYTE_ZERO};
					held_q <= ansp_pkg::CODE_LEN_4;
					len_q  <= ansp_pkg::CODE_LEN_4;
				end else begin
					win_q  <= {ansp_pkg::BYTE_ZERO, ansp_pkg::BYTE_ONE,
						ansp_pkg::BYTE_ZERO, ansp_pkg::BYTE_ZERO};
					held_q <= ansp_pkg::CODE_LEN_3;
					len_q  <= ansp_pkg::CODE_LEN_3;
				end
				firstp_q <= 1'b1;
				inside_q <= 1'b1;
			end else begin
				if (held_q == ansp_pkg::HOLD_FULL) begin
					for (int i = 0; i < ansp_pkg::HOLD_DEPTH - 1; i++) begin
						win_q[i] <= win_q[i+1];
					end
					win_q[ansp_pkg::HOLD_DEPTH-1] <= up.in_byte;
				end else begin
					win_q[held_q[1:0]] <= up.in_byte;
					held_q             <= held_q + 3'd1;
				end
				if (bundle.cnt != 3'd0) begin
					firstp_q <= 1'b0;
				end
			end
		end
	end

	`ASSERT_CLK(a_held_range, clk, arst_n, held_q <= ansp_pkg::HOLD_FULL,
		"held byte count out of range")
	`ASSERT_IMPL(a_inside_holds_code, clk, arst_n, inside_q, held_q >= ansp_pkg::CODE_LEN_3,
		"open unit without its start code held")

endmodule

// ----- rtl/core/ansp_fifo.sv -----
`include "assert_macros.svh"

module ansp_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ansp_pkg::bundle_t wr_data,
	input  logic              pop,
	output logic              full,
	output ansp_pkg::q_stat_t stat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ansp_pkg::bundle_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_IMPL(a_no_push_full, clk, arst_n, full, !push, "push into full queue")
	`ASSERT_IMPL(a_no_pop_empty, clk, arst_n, stat.empty, !pop, "pop from empty queue")

endmodule

// ----- rtl/core/ansp_back.sv -----
`include "assert_macros.svh"

module ansp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ansp_pkg::q_stat_t stat,
	output logic              pop,
	ansp_out_if.source        dn
);

	logic       valid_q;
	logic [1:0] idx_q;
	logic       load;
	logic       at_end;

	assign load   = !valid_q || dn.ready;
	assign at_end = ({1'b0, idx_q} == (stat.head.cnt - 3'd1));
	assign pop    = load && !stat.empty && at_end;

	assign dn.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= !stat.empty;
			if (!stat.empty) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (load && !stat.empty) begin
			dn.out_byte    <= stat.head.bytes[idx_q];
			dn.unit_first  <= stat.head.first && (idx_q == 2'd0);
			dn.unit_last   <= stat.head.last && at_end;
			dn.code_length <= stat.head.code_len;
		end
	end

	`ASSERT_IMPL(a_idx_needs_entry, clk, arst_n, idx_q != 2'd0, !stat.empty,
		"mid-group index with empty queue")

endmodule

// ----- rtl/core/annexb_nal_unit_splitter_core.sv -----
// annex b nal unit splitter: takes a byte stream one word per cycle on ingress and
// passes every byte of every nal unit on egress, start codes included, with flags for the
// first and last byte of each unit and the unit's start code length (3 for 00 00 01,
// 4 for 00 00 00 01, the 4-byte form winning). bytes before the first start code are
// dropped. up to four bytes are held back; a word with stream_end set flushes them,
// marks the final one last and returns the block to its reset state. ingress takes
// one word per cycle while the group queue has room; a word releases 0 to 2 output
// words (0 to 4 on stream end) and egress delivers one word per cycle while egress is
// ready, so the sustained rate is one byte per cycle, set by the single output
// register; bursts are absorbed by the queue of QUEUE_DEPTH groups.
module annexb_nal_unit_splitter_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	ansp_in_if.sink    ingress,
	ansp_out_if.source egress
);

	// front to queue
	logic              push;
	logic              q_full;
	ansp_pkg::bundle_t bundle;

	// queue to back
	ansp_pkg::q_stat_t q_stat;
	logic              pop;

	// front: start code detection and hold window
	ansp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (ingress),
		.q_full (q_full),
		.push   (push),
		.bundle (bundle)
	);

	// short queue of word groups, decouples the two sides
	ansp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (bundle),
		.pop     (pop),
		.full    (q_full),
		.stat    (q_stat)
	);

	// back: serializes each group into single output words
	ansp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (q_stat),
		.pop    (pop),
		.dn     (egress)
	);

endmodule
